/* design/rfws_pkg.sv */
// rfws_pkg: shared types and constants of the rgb fade walk sequencer
`timescale 1ns / 1ps
package rfws_pkg;

  // phase codes of the sequencer
  localparam logic [2:0] PH_INIT      = 3'd0;
  localparam logic [2:0] PH_TO_DIM    = 3'd1;
  localparam logic [2:0] PH_TO_FULL   = 3'd2;
  localparam logic [2:0] PH_HOLD      = 3'd3;
  localparam logic [2:0] PH_FROM_FULL = 3'd4;
  localparam logic [2:0] PH_TO_WHITE  = 3'd5;
  localparam logic [2:0] PH_ADVANCE   = 3'd6;

  // colour codes
  localparam logic [1:0] COL_RED   = 2'd0;
  localparam logic [1:0] COL_GREEN = 2'd1;
  localparam logic [1:0] COL_BLUE  = 2'd2;

  localparam logic [7:0] FULL_LEVEL = 8'd255;
  localparam logic [7:0] DIM_RESET  = 8'd8;

  // widths of fixed fields
  localparam int LED_NUM_W = 6;
  localparam int STEP_W    = 4;
  localparam int PROD_W    = 12;

  // reciprocal multiply for the ramp divide
  localparam int RECIP_SHIFT = 24;
  localparam int RECIP_W     = RECIP_SHIFT + 1;
  localparam int QPROD_W     = PROD_W + RECIP_W;

  // command queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;
  localparam int QCNT_W      = 2;

  // one command from the front: an init sweep or one ramp write
  typedef struct packed {
    logic                 init;
    logic [2:0]           phase;
    logic [1:0]           colour;
    logic [LED_NUM_W-1:0] led;
    logic [STEP_W-1:0]    step;
  } cmd_t;

  // one write travelling down the back pipeline
  typedef struct packed {
    logic                 init;
    logic                 last;
    logic [2:0]           phase;
    logic [1:0]           colour;
    logic [LED_NUM_W-1:0] led;
    logic                 down;
    logic [7:0]           base;
  } item_t;

endpackage

/* design/rfws_queue.sv */
// rfws_queue: short command queue between the front and the back
`timescale 1ns / 1ps
module rfws_queue
  import rfws_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  output logic head_valid,
  output cmd_t head_cmd,
  input  logic pop
);

  cmd_t              entry_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;
  logic              do_push, do_pop;

  assign full       = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign head_valid = (count_r != '0);
  assign head_cmd   = entry_r[rd_ptr_r];

  assign do_push = push && !full;
  assign do_pop  = pop && head_valid;

  // pointer and count update
  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

/* design/rfws_front.sv */
// rfws_front: tick intake, sequencer state, dim level register, command issue
`timescale 1ns / 1ps
module rfws_front
  import rfws_pkg::*;
#(
  parameter int LED_COUNT = 4,
  parameter int STEPS     = 10
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       in_waiting_mode,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_dim_level,
  output logic [7:0] dim_level,
  output logic       cmd_push,
  output cmd_t       cmd,
  input  logic       cmd_full
);

  localparam int LED_W = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;

  logic [2:0]        phase_r, phase_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [1:0]        colour_r, colour_nxt;
  logic [LED_W-1:0]  led_r, led_nxt;
  logic [7:0]        dim_r;
  logic              accept;

  assign in_stall  = cmd_full;
  assign accept    = in_valid && !cmd_full;
  assign cfg_ready = 1'b1;
  assign dim_level = dim_r;

  // command fields come from the state before the update
  always_comb begin
    cmd.init   = 1'b0;
    cmd.phase  = phase_r;
    cmd.colour = colour_r;
    cmd.led    = LED_NUM_W'(led_r);
    cmd.step   = step_r;
    cmd_push   = 1'b0;
    phase_nxt  = phase_r;
    step_nxt   = step_r;
    colour_nxt = colour_r;
    led_nxt    = led_r;
    if (accept) begin
      if (!in_waiting_mode) begin
        phase_nxt  = PH_INIT;
        step_nxt   = '0;
        colour_nxt = COL_RED;
        led_nxt    = '0;
      end else begin
        unique case (phase_r) inside
          PH_TO_DIM, PH_TO_FULL, PH_HOLD, PH_FROM_FULL, PH_TO_WHITE: begin
            cmd_push = 1'b1;
            if (phase_r == PH_HOLD) begin
              phase_nxt = PH_FROM_FULL;
            end else if (step_r >= STEP_W'(STEPS)) begin
              step_nxt  = '0;
              phase_nxt = phase_r + 3'd1;
            end else begin
              step_nxt = step_r + 1'b1;
            end
          end
          PH_ADVANCE: begin
            phase_nxt = PH_TO_DIM;
            if (colour_r == COL_BLUE) begin
              colour_nxt = COL_RED;
              led_nxt    = (led_r == LED_W'(LED_COUNT - 1)) ? '0 : led_r + 1'b1;
            end else begin
              colour_nxt = colour_r + 2'd1;
            end
          end
          default: begin
            // initialise, also for codes that are never reached
            cmd.init  = 1'b1;
            cmd_push  = 1'b1;
            phase_nxt = PH_TO_DIM;
            step_nxt  = '0;
          end
        endcase
      end
    end
  end

  // sequencer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_INIT;
      step_r   <= '0;
      colour_r <= COL_RED;
      led_r    <= '0;
    end else begin
      phase_r  <= phase_nxt;
      step_r   <= step_nxt;
      colour_r <= colour_nxt;
      led_r    <= led_nxt;
    end
  end

  // dim level register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dim_r <= DIM_RESET;
    end else if (cfg_valid) begin
      dim_r <= cfg_dim_level;
    end
  end

endmodule

/* design/rfws_back.sv */
// rfws_back: expands commands into led writes through the ramp pipeline
`timescale 1ns / 1ps
module rfws_back
  import rfws_pkg::*;
#(
  parameter int LED_COUNT = 4,
  parameter int STEPS     = 10
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [7:0]           dim_level,
  input  logic                 head_valid,
  input  cmd_t                 head_cmd,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [LED_NUM_W-1:0] out_led_number,
  output logic [7:0]           out_red_level,
  output logic [7:0]           out_green_level,
  output logic [7:0]           out_blue_level,
  output logic                 out_last_write
);

  localparam int LED_W = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'(STEPS) - 64'd1) / 64'(STEPS));

  logic              adv;
  logic [LED_W-1:0]  init_cnt_r, init_cnt_nxt;
  logic              init_last;
  item_t             issue;
  logic [7:0]        diff;
  logic [PROD_W-1:0] prod;

  logic              s1_valid_r;
  item_t             s1_item_r;
  logic [PROD_W-1:0] s1_prod_r;

  logic               s2_valid_r;
  item_t              s2_item_r;
  logic [7:0]         s2_quot_r;
  logic [QPROD_W-1:0] qprod;

  logic       out_valid_r;
  logic [LED_NUM_W-1:0] out_led_r;
  logic [7:0] out_red_r, out_green_r, out_blue_r;
  logic       out_last_r;
  logic [7:0] ramp_val;
  logic [7:0] sel_val, other_val;
  logic [7:0] red_nxt, green_nxt, blue_nxt;

  // whole pipeline moves when the output register can take a write
  assign adv = !out_valid_r || !out_stall;

  // issue: one write per cycle while adv is high; init commands sweep over all leds
  assign init_last = (init_cnt_r == LED_W'(LED_COUNT - 1));
  assign pop       = adv && head_valid && (!head_cmd.init || init_last);

  always_comb begin
    init_cnt_nxt = init_cnt_r;
    if (head_valid && head_cmd.init) begin
      init_cnt_nxt = init_last ? '0 : init_cnt_r + 1'b1;
    end
  end

  // ramp operands per phase
  always_comb begin
    issue.init   = head_cmd.init;
    issue.last   = head_cmd.init ? init_last : 1'b1;
    issue.phase  = head_cmd.phase;
    issue.colour = head_cmd.colour;
    issue.led    = head_cmd.init ? LED_NUM_W'(init_cnt_r) : head_cmd.led;
    issue.down   = 1'b0;
    issue.base   = 8'd0;
    diff         = 8'd0;
    unique case (head_cmd.phase)
      PH_TO_DIM: begin
        issue.base = dim_level;
        issue.down = 1'b1;
        diff       = dim_level;
      end
      PH_TO_FULL: begin
        issue.base = dim_level;
        diff       = FULL_LEVEL - dim_level;
      end
      PH_FROM_FULL: begin
        issue.base = FULL_LEVEL;
        issue.down = 1'b1;
        diff       = FULL_LEVEL - dim_level;
      end
      PH_TO_WHITE: begin
        diff = dim_level;
      end
      default: begin
        diff = 8'd0;
      end
    endcase
    // a downward ramp rounds its step toward the target
    prod = PROD_W'(diff) * PROD_W'(head_cmd.step);
    if (issue.down) begin
      prod = prod + PROD_W'(STEPS - 1);
    end
  end

  // divide by the step count through the reciprocal
  assign qprod = QPROD_W'(s1_prod_r) * QPROD_W'(RECIP);

  // final ramp value and channel assembly
  always_comb begin
    ramp_val  = s2_item_r.down ? s2_item_r.base - s2_quot_r : s2_item_r.base + s2_quot_r;
    sel_val   = 8'd0;
    other_val = 8'd0;
    unique case (s2_item_r.phase) inside
      PH_TO_DIM, PH_TO_WHITE: begin
        sel_val   = dim_level;
        other_val = ramp_val;
      end
      PH_TO_FULL, PH_FROM_FULL: begin
        sel_val = ramp_val;
      end
      PH_HOLD: begin
        sel_val = FULL_LEVEL;
      end
      default: begin
        sel_val = 8'd0;
      end
    endcase
    red_nxt   = (s2_item_r.colour == COL_RED)   ? sel_val : other_val;
    green_nxt = (s2_item_r.colour == COL_GREEN) ? sel_val : other_val;
    blue_nxt  = (s2_item_r.colour == COL_BLUE)  ? sel_val : other_val;
    if (s2_item_r.init) begin
      red_nxt   = dim_level;
      green_nxt = dim_level;
      blue_nxt  = dim_level;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      init_cnt_r  <= '0;
    end else if (adv) begin
      s1_valid_r  <= head_valid;
      s2_valid_r  <= s1_valid_r;
      out_valid_r <= s2_valid_r;
      init_cnt_r  <= init_cnt_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_item_r   <= issue;
      s1_prod_r   <= prod;
      s2_item_r   <= s1_item_r;
      s2_quot_r   <= qprod[RECIP_SHIFT +: 8];
      out_led_r   <= s2_item_r.led;
      out_red_r   <= red_nxt;
      out_green_r <= green_nxt;
      out_blue_r  <= blue_nxt;
      out_last_r  <= s2_item_r.last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_led_number  = out_led_r;
  assign out_red_level   = out_red_r;
  assign out_green_level = out_green_r;
  assign out_blue_level  = out_blue_r;
  assign out_last_write  = out_last_r;

endmodule

/* design/rgb_fade_walk_sequencer.sv */
// rgb_fade_walk_sequencer: top level of the led waiting-animation sequencer
//
// Usage: each input transaction is one animation tick carrying in_waiting_mode.
// A tick with the mode bit clear returns the sequencer to its start and makes
// no write. The first tick after that paints all LED_COUNT leds dim white, and
// later ticks walk red, green and blue fades over one led at a time, one led
// write per tick, with an empty tick between colours.
// Each write leaves on the out_ channel; out_last_write marks the final write
// of a tick. cfg_dim_level sets the dim level (reset 8); cfg_ready is always
// high. The user writes the port only while no tick is in flight; the block
// itself does not enforce this. A tick's first write passes the command queue
// and then issue, reciprocal multiply and channel assembly to the output.
// The back pipeline emits one write per cycle unless out_stall holds it; a ramp
// tick makes one write and the dim white sweep LED_COUNT writes. Ticks enter
// through a two-entry command queue; in_stall is high only while it is full.
// Reset clears the sequencer state, the queue and the pipeline at once.
// While out_stall is high and a write waits on the output, the whole back
// pipeline holds; the front keeps taking ticks until the queue fills.
`timescale 1ns / 1ps
module rgb_fade_walk_sequencer
  import rfws_pkg::*;
#(
  parameter int LED_COUNT = 4,
  parameter int STEPS     = 10
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       in_waiting_mode,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [5:0] out_led_number,
  output logic [7:0] out_red_level,
  output logic [7:0] out_green_level,
  output logic [7:0] out_blue_level,
  output logic       out_last_write,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_dim_level
);

  logic [7:0] dim_level;
  logic       cmd_push;
  cmd_t       cmd;
  logic       cmd_full;
  logic       head_valid;
  cmd_t       head_cmd;
  logic       pop;

  // tick intake and sequencer state
  rfws_front #(
    .LED_COUNT (LED_COUNT),
    .STEPS     (STEPS)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_waiting_mode (in_waiting_mode),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_dim_level   (cfg_dim_level),
    .dim_level       (dim_level),
    .cmd_push        (cmd_push),
    .cmd             (cmd),
    .cmd_full        (cmd_full)
  );

  // command queue
  rfws_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (cmd_push),
    .push_cmd   (cmd),
    .full       (cmd_full),
    .head_valid (head_valid),
    .head_cmd   (head_cmd),
    .pop        (pop)
  );

  // write generation
  rfws_back #(
    .LED_COUNT (LED_COUNT),
    .STEPS     (STEPS)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .dim_level       (dim_level),
    .head_valid      (head_valid),
    .head_cmd        (head_cmd),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_led_number  (out_led_number),
    .out_red_level   (out_red_level),
    .out_green_level (out_green_level),
    .out_blue_level  (out_blue_level),
    .out_last_write  (out_last_write)
  );

endmodule
